// ===== rtl/gdad_pkg.sv =====
package gdad_pkg;

    localparam int YEAR_LIMIT_DEF = 9999;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ADD_W   = 20;
    localparam int ORD_W   = 23;
    localparam int YR_W    = 16;

    localparam int DAYS_400 = 146097;
    localparam int DAYS_100 = 36524;
    localparam int DAYS_4   = 1461;
    localparam int DAYS_1   = 365;

    localparam int RECIP_K   = 32;
    localparam int DIV100_M  = 5243;
    localparam int DIV100_SH = 19;

    localparam int MONTHS  = 12;
    localparam int FEB_IDX = 1;

    // days before month m (0 is January)
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && m > MONTH_W'(FEB_IDX))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== rtl/gdad_if.sv =====
interface gdad_in_if;
    import gdad_pkg::*;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [ADD_W-1:0]   add_days;
    modport source(output valid, start_year, start_month, start_day, add_days, input ready);
    modport sink(input valid, start_year, start_month, start_day, add_days, output ready);
endinterface

interface gdad_out_if;
    import gdad_pkg::*;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic               overflow;
    modport source(output valid, result_year, result_month, result_day, overflow, input ready);
    modport sink(input valid, result_year, result_month, result_day, overflow, output ready);
endinterface

// ===== rtl/gregorian_date_add_days_core.sv =====
// gregorian date plus day count
// din (sink): start_year, start_month, start_day, add_days; a word moves
//   when valid and ready are high at a rising clk edge
// dout (source): result_year, result_month, result_day, overflow
// one result word per input word, in order
// throughput: one word per cycle unless stalled; the 13 register stages
//   each hold one word (3 stages to the day ordinal, 10 stages back
//   through 400/100/4/1-year chunks by reciprocal multiply (400, 4) or
//   compare (100, 1), and the month compare)
// the whole pipeline advances together; din.ready is low only while a
//   finished word sits in the output register and dout.ready is low,
//   so a stall holds every stage and nothing is dropped or repeated
// reset (rst_n low, asynchronous) empties the pipeline; words in flight
//   are discarded and dout.valid goes low
// a result year above YEAR_LIMIT gives overflow with 31 December of YEAR_LIMIT
module gregorian_date_add_days_core #(
    parameter int YEAR_LIMIT = gdad_pkg::YEAR_LIMIT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    gdad_in_if.sink       din,
    gdad_out_if.source    dout
);
    import gdad_pkg::*;

    localparam longint M400  = (64'd1 << RECIP_K) / DAYS_400;
    localparam longint M1461 = (64'd1 << RECIP_K) / DAYS_4;
    localparam int     M400_W  = $clog2(M400 + 1);
    localparam int     M1461_W = $clog2(M1461 + 1);

    logic             out_vld_reg;
    logic             en;
    logic             ov;
    logic [ORD_W-1:0] r0;

    assign en        = !out_vld_reg || dout.ready;
    assign din.ready = en;

    gdad_to_ordinal u_to_ord (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .vld         (din.valid),
        .start_year  (din.start_year),
        .start_month (din.start_month),
        .start_day   (din.start_day),
        .add_days    (din.add_days),
        .ord_vld     (ov),
        .ord_m1      (r0)
    );

    // b1: estimate of 400-year quotient
    logic [ORD_W+M400_W-1:0] prod400;
    logic             v1_reg;
    logic [ORD_W-1:0] r1_reg;
    logic [5:0]       q1_reg, q1_next;
    // b2: remainder
    logic             v2_reg;
    logic [ORD_W-1:0] r2_reg, r2_next;
    logic [5:0]       q2_reg;
    // b3: correction
    logic             v3_reg;
    logic [17:0]      r3_reg, r3_next;
    logic [5:0]       q400_3_reg, q400_3_next;
    // b4: century
    logic             v4_reg;
    logic [15:0]      r4_reg, r4_next;
    logic [5:0]       q400_4_reg;
    logic [1:0]       q100_4_reg, q100_4_next;
    // b5: estimate of 4-year quotient
    logic [16+M1461_W-1:0] prod4;
    logic             v5_reg;
    logic [15:0]      r5_reg;
    logic [4:0]       q4_5_reg, q4_5_next;
    logic [5:0]       q400_5_reg;
    logic [1:0]       q100_5_reg;
    // b6: remainder
    logic             v6_reg;
    logic [15:0]      r6_reg, r6_next;
    logic [4:0]       q4_6_reg;
    logic [5:0]       q400_6_reg;
    logic [1:0]       q100_6_reg;
    // b7: correction
    logic             v7_reg;
    logic [10:0]      r7_reg, r7_next;
    logic [4:0]       q4_7_reg, q4_7_next;
    logic [5:0]       q400_7_reg;
    logic [1:0]       q100_7_reg;
    // b8: single years, year number, leap
    logic [1:0]       q1y;
    logic             v8_reg;
    logic [8:0]       r8_reg, r8_next;
    logic [YR_W-1:0]  yr8_reg, yr8_next;
    logic             lp8_reg, lp8_next;
    // b9: month index
    logic             v9_reg;
    logic [8:0]       r9_reg;
    logic [YR_W-1:0]  yr9_reg;
    logic             lp9_reg;
    logic [MONTH_W-1:0] m9_reg, m9_next;
    // b10: output
    logic [YEAR_W-1:0]  oy_reg, oy_next;
    logic [MONTH_W-1:0] om_reg, om_next;
    logic [DAY_W-1:0]   od_reg, od_next;
    logic               oo_reg, oo_next;

    always_comb
    begin
        prod400 = (ORD_W+M400_W)'(r0) * (ORD_W+M400_W)'(M400);
        q1_next = 6'(prod400 >> RECIP_K);

        r2_next = r1_reg - ORD_W'(q1_reg) * ORD_W'(DAYS_400);

        if (r2_reg >= ORD_W'(DAYS_400))
        begin
            q400_3_next = q2_reg + 6'd1;
            r3_next     = 18'(r2_reg - ORD_W'(DAYS_400));
        end
        else
        begin
            q400_3_next = q2_reg;
            r3_next     = 18'(r2_reg);
        end

        if (r3_reg >= 18'(3 * DAYS_100))
        begin
            q100_4_next = 2'd3;
            r4_next     = 16'(r3_reg - 18'(3 * DAYS_100));
        end
        else if (r3_reg >= 18'(2 * DAYS_100))
        begin
            q100_4_next = 2'd2;
            r4_next     = 16'(r3_reg - 18'(2 * DAYS_100));
        end
        else if (r3_reg >= 18'(DAYS_100))
        begin
            q100_4_next = 2'd1;
            r4_next     = 16'(r3_reg - 18'(DAYS_100));
        end
        else
        begin
            q100_4_next = 2'd0;
            r4_next     = 16'(r3_reg);
        end

        prod4     = (16+M1461_W)'(r4_reg) * (16+M1461_W)'(M1461);
        q4_5_next = 5'(prod4 >> RECIP_K);

        r6_next = r5_reg - 16'(q4_5_reg) * 16'(DAYS_4);

        if (r6_reg >= 16'(DAYS_4))
        begin
            q4_7_next = q4_6_reg + 5'd1;
            r7_next   = 11'(r6_reg - 16'(DAYS_4));
        end
        else
        begin
            q4_7_next = q4_6_reg;
            r7_next   = 11'(r6_reg);
        end

        if (r7_reg >= 11'(3 * DAYS_1))
        begin
            q1y = 2'd3;
        end
        else if (r7_reg >= 11'(2 * DAYS_1))
        begin
            q1y = 2'd2;
        end
        else if (r7_reg >= 11'(DAYS_1))
        begin
            q1y = 2'd1;
        end
        else
        begin
            q1y = 2'd0;
        end
        r8_next  = 9'(r7_reg - 11'(q1y) * 11'(DAYS_1));
        yr8_next = YR_W'(q400_7_reg) * YR_W'(400) + YR_W'(q100_7_reg) * YR_W'(100)
                 + YR_W'(q4_7_reg) * YR_W'(4) + YR_W'(q1y) + YR_W'(1);
        lp8_next = (q1y == 2'd3) && ((q4_7_reg != 5'd24) || (q100_7_reg == 2'd3));

        m9_next = '0;
        for (int k = 1; k < MONTHS; k++)
        begin
            if (r8_reg >= cum_days(MONTH_W'(k), lp8_reg))
            begin
                m9_next = m9_next + MONTH_W'(1);
            end
        end

        if (yr9_reg > YR_W'(YEAR_LIMIT))
        begin
            oy_next = YEAR_W'(YEAR_LIMIT);
            om_next = MONTH_W'(MONTHS);
            od_next = DAY_W'(31);
            oo_next = 1'b1;
        end
        else
        begin
            oy_next = YEAR_W'(yr9_reg);
            om_next = m9_reg + MONTH_W'(1);
            od_next = DAY_W'(r9_reg - cum_days(m9_reg, lp9_reg) + 9'd1);
            oo_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= ov;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg;
            v9_reg      <= v8_reg;
            out_vld_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg     <= r0;
            q1_reg     <= q1_next;
            r2_reg     <= r2_next;
            q2_reg     <= q1_reg;
            r3_reg     <= r3_next;
            q400_3_reg <= q400_3_next;
            r4_reg     <= r4_next;
            q400_4_reg <= q400_3_reg;
            q100_4_reg <= q100_4_next;
            r5_reg     <= r4_reg;
            q4_5_reg   <= q4_5_next;
            q400_5_reg <= q400_4_reg;
            q100_5_reg <= q100_4_reg;
            r6_reg     <= r6_next;
            q4_6_reg   <= q4_5_reg;
            q400_6_reg <= q400_5_reg;
            q100_6_reg <= q100_5_reg;
            r7_reg     <= r7_next;
            q4_7_reg   <= q4_7_next;
            q400_7_reg <= q400_6_reg;
            q100_7_reg <= q100_6_reg;
            r8_reg     <= r8_next;
            yr8_reg    <= yr8_next;
            lp8_reg    <= lp8_next;
            r9_reg     <= r8_reg;
            yr9_reg    <= yr8_reg;
            lp9_reg    <= lp8_reg;
            m9_reg     <= m9_next;
            oy_reg     <= oy_next;
            om_reg     <= om_next;
            od_reg     <= od_next;
            oo_reg     <= oo_next;
        end
    end

    assign dout.valid        = out_vld_reg;
    assign dout.result_year  = oy_reg;
    assign dout.result_month = om_reg;
    assign dout.result_day   = od_reg;
    assign dout.overflow     = oo_reg;

    a_rem400_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (r3_reg < 18'(DAYS_400)))
        else $error("400-year remainder out of range");

    a_rem4_range: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg |-> (r7_reg < 11'(DAYS_4)))
        else $error("4-year remainder out of range");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        v9_reg |-> (m9_reg < MONTH_W'(MONTHS)))
        else $error("month index out of range");

    a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.overflow) |->
            (dout.result_month == MONTH_W'(MONTHS) && dout.result_day == DAY_W'(31)))
        else $error("overflow word without saturated date");

endmodule

// ===== rtl/gdad_to_ordinal.sv =====
module gdad_to_ordinal (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          vld,
    input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
    input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
    input  logic [gdad_pkg::DAY_W-1:0]    start_day,
    input  logic [gdad_pkg::ADD_W-1:0]    add_days,
    output logic                          ord_vld,
    output logic [gdad_pkg::ORD_W-1:0]    ord_m1
);
    import gdad_pkg::*;

    // stage 1: year scaling and divide-by-100 products
    logic [YEAR_W-1:0]  y_c;
    logic [MONTH_W-1:0] mo_c;
    logic [YEAR_W-1:0]  p;
    logic [11:0]        p4;
    logic [26:0]        p_m100;
    logic [25:0]        p4_m100;
    logic [26:0]        y_m100;
    logic [25:0]        y4_m100;

    logic               v1_reg;
    logic [YEAR_W-1:0]  y1_reg;
    logic [MONTH_W-1:0] mo1_reg;
    logic [DAY_W-1:0]   d1_reg;
    logic [ADD_W-1:0]   add1_reg;
    logic [ORD_W-1:0]   p365_reg, p365_next;
    logic [11:0]        p4_reg;
    logic [7:0]         p100_reg, p100_next;
    logic [5:0]         p400_reg, p400_next;
    logic [7:0]         qy_reg, qy_next;
    logic [5:0]         qy4_reg, qy4_next;

    always_comb
    begin
        y_c     = (start_year == '0) ? YEAR_W'(1) : start_year;
        mo_c    = (start_month == '0) ? MONTH_W'(1) :
                  (start_month > MONTH_W'(MONTHS)) ? MONTH_W'(MONTHS) : start_month;
        p       = y_c - YEAR_W'(1);
        p4      = p[YEAR_W-1:2];
        p_m100  = 27'(p) * 27'(DIV100_M);
        p4_m100 = 26'(p4) * 26'(DIV100_M);
        y_m100  = 27'(y_c) * 27'(DIV100_M);
        y4_m100 = 26'(y_c[YEAR_W-1:2]) * 26'(DIV100_M);
        p365_next = ORD_W'(p) * ORD_W'(DAYS_1);
        p100_next = 8'(p_m100 >> DIV100_SH);
        p400_next = 6'(p4_m100 >> DIV100_SH);
        qy_next   = 8'(y_m100 >> DIV100_SH);
        qy4_next  = 6'(y4_m100 >> DIV100_SH);
    end

    // stage 2: leap test, whole-year day count and days before the month
    logic                leap;
    logic               v2_reg;
    logic [ORD_W-1:0]   days2_reg, days2_next;
    logic [8:0]         cum2_reg, cum2_next;
    logic [DAY_W-1:0]   d2_reg;
    logic [ADD_W-1:0]   add2_reg;

    always_comb
    begin
        leap = (y1_reg[1:0] == 2'd0) &&
               ((15'(y1_reg) != 15'(qy_reg) * 15'd100) ||
                (13'(y1_reg[YEAR_W-1:2]) == 13'(qy4_reg) * 13'd100));
        days2_next = p365_reg + ORD_W'(p4_reg) - ORD_W'(p100_reg) + ORD_W'(p400_reg);
        cum2_next  = cum_days(mo1_reg - MONTH_W'(1), leap);
    end

    // stage 3: ordinal, add, minus one
    logic [ORD_W:0]     ord;
    logic [ORD_W:0]     ord_fix;
    logic               v3_reg;
    logic [ORD_W-1:0]   r3_reg, r3_next;

    always_comb
    begin
        ord     = (ORD_W+1)'(days2_reg) + (ORD_W+1)'(cum2_reg) + (ORD_W+1)'(d2_reg);
        ord_fix = (ord == '0) ? (ORD_W+1)'(1) : ord;
        r3_next = ORD_W'(ord_fix + (ORD_W+1)'(add2_reg) - (ORD_W+1)'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg    <= y_c;
            mo1_reg   <= mo_c;
            d1_reg    <= start_day;
            add1_reg  <= add_days;
            p365_reg  <= p365_next;
            p4_reg    <= p4;
            p100_reg  <= p100_next;
            p400_reg  <= p400_next;
            qy_reg    <= qy_next;
            qy4_reg   <= qy4_next;
            days2_reg <= days2_next;
            cum2_reg  <= cum2_next;
            d2_reg    <= d1_reg;
            add2_reg  <= add1_reg;
            r3_reg    <= r3_next;
        end
    end

    assign ord_vld = v3_reg;
    assign ord_m1  = r3_reg;

endmodule
